[design/pool_allocator_evict_oldest_defines.svh]
// Assertion macros shared by the pool allocator RTL.
`ifndef POOL_ALLOCATOR_EVICT_OLDEST_DEFINES_SVH
`define POOL_ALLOCATOR_EVICT_OLDEST_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cond holds at every clock edge out of reset.
`define PAE_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pool allocator check failed");
// Check that trig at one edge is followed by cond at the next edge.
`define PAE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("pool allocator sequence check failed");
`else
`define PAE_ASSERT(lbl, clk, rst_n, cond)
`define PAE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)
`endif

`endif

[design/pae_pkg.sv]
`default_nettype none

package pae_pkg;

    // Pool size and derived widths
    localparam int SLOTS  = 256;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = 8;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIX
    } state_t;

    // Where an allocate takes its slot from, or a free
    typedef enum logic [1:0] {
        KIND_POP,
        KIND_FILL,
        KIND_EVICT,
        KIND_FREE
    } kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic fix;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_fix;
    } status_t;

endpackage

`default_nettype wire

[design/pae_ctrl.sv]
`default_nettype none

module pae_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  pae_pkg::status_t sts,
    output logic             busy,
    output pae_pkg::cmd_t    cmd
);
    import pae_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one request: load, execute, and an optional link fix-up
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.need_fix)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/pae_datapath.sv]
`default_nettype none

module pae_datapath (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  pae_pkg::cmd_t                       cmd,
    input  wire                                 req_type,
    input  wire  [pae_pkg::IDX_W-1:0]           slot_index,
    output pae_pkg::status_t                    sts,
    output logic                                done,
    output logic [pae_pkg::IDX_W-1:0]           granted_slot,
    output logic                                evicted,
    output logic                                bad_free
);
    import pae_pkg::*;

    // Link memories, undefined until written
    logic [SLOT_W-1:0] older_mem [SLOTS];
    logic [SLOT_W-1:0] newer_mem [SLOTS];

    // Pool state
    logic [SLOTS-1:0]  in_use_reg;
    logic              freed_valid_reg;
    logic [SLOT_W-1:0] freed_top_reg;
    logic [SLOT_W:0]   fill_count_reg;
    logic              newest_valid_reg;
    logic [SLOT_W-1:0] newest_reg;
    logic              oldest_valid_reg;
    logic [SLOT_W-1:0] oldest_reg;

    // Request in flight
    kind_t             kind_reg;
    logic [SLOT_W-1:0] s_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              bad_reg;
    logic              unl_reg;
    logic [SLOT_W-1:0] rd_older_reg;
    logic [SLOT_W-1:0] rd_newer_reg;
    logic [SLOT_W-1:0] link_reg;

    // Result word
    logic              done_reg;
    logic [IDX_W-1:0]  granted_reg;
    logic              evicted_reg;
    logic              bad_free_reg;

    // Load-time decode
    kind_t             kind_load;
    logic [SLOT_W-1:0] s_load;
    logic              bad_load;
    logic              unl_load;

    // Execute-time values
    logic [SLOT_W-1:0] o_link;
    logic [SLOT_W-1:0] n_link;
    logic              has_older;
    logic              has_newer;
    logic              do_unlink;
    logic              both_sides;
    logic [SLOT_W-1:0] free_link;
    logic              newest_valid_next;
    logic [SLOT_W-1:0] newest_next;
    logic              oldest_valid_next;
    logic [SLOT_W-1:0] oldest_next;
    logic              freed_valid_next;
    logic [SLOT_W-1:0] freed_top_next;

    // Memory write ports
    logic              ow_en;
    logic [SLOT_W-1:0] ow_addr;
    logic [SLOT_W-1:0] ow_data;
    logic              nw_en;
    logic [SLOT_W-1:0] nw_addr;
    logic [SLOT_W-1:0] nw_data;

    // Pick an alloc slot (free stack, never-used, oldest in use) or check a free
    always_comb
    begin
        kind_load = KIND_FREE;
        s_load    = SLOT_W'(slot_index);
        bad_load  = 1'b0;
        unl_load  = 1'b0;
        if (req_type == REQ_ALLOC)
        begin
            if (freed_valid_reg)
            begin
                kind_load = KIND_POP;
                s_load    = freed_top_reg;
            end
            else if (32'(fill_count_reg) < SLOTS)
            begin
                kind_load = KIND_FILL;
                s_load    = fill_count_reg[SLOT_W-1:0];
            end
            else
            begin
                kind_load = KIND_EVICT;
                s_load    = oldest_valid_reg ? oldest_reg : '0;
                unl_load  = oldest_valid_reg && in_use_reg[oldest_reg];
            end
        end
        else
        begin
            bad_load = !(32'(slot_index) < SLOTS) || !in_use_reg[s_load];
        end
    end

    // Latch the request and read both links of the chosen slot
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= kind_load;
            s_reg        <= s_load;
            idx_reg      <= slot_index;
            bad_reg      <= bad_load;
            unl_reg      <= unl_load;
            rd_older_reg <= older_mem[s_load];
            rd_newer_reg <= newer_mem[s_load];
        end
        if (cmd.exec)
        begin
            link_reg <= free_link;
        end
    end

    // Work out list and stack updates from the links just read
    always_comb
    begin
        o_link    = (32'(rd_older_reg) < SLOTS) ? rd_older_reg : '0;
        n_link    = (32'(rd_newer_reg) < SLOTS) ? rd_newer_reg : '0;
        has_older = !(oldest_valid_reg && (s_reg == oldest_reg));
        has_newer = !(newest_valid_reg && (s_reg == newest_reg));
        do_unlink = ((kind_reg == KIND_EVICT) && unl_reg)
                    || ((kind_reg == KIND_FREE) && !bad_reg);
        both_sides = do_unlink && has_older && has_newer;
        free_link  = freed_valid_reg ? freed_top_reg : s_reg;

        newest_valid_next = newest_valid_reg;
        newest_next       = newest_reg;
        oldest_valid_next = oldest_valid_reg;
        oldest_next       = oldest_reg;
        freed_valid_next  = freed_valid_reg;
        freed_top_next    = freed_top_reg;

        ow_en   = 1'b0;
        ow_addr = s_reg;
        ow_data = link_reg;
        nw_en   = 1'b0;
        nw_addr = s_reg;
        nw_data = s_reg;

        // Unlink from the age list; only an inner slot touches the memories
        if (do_unlink && !both_sides)
        begin
            if (has_older)
            begin
                newest_valid_next = 1'b1;
                newest_next       = o_link;
            end
            else if (has_newer)
            begin
                oldest_valid_next = 1'b1;
                oldest_next       = n_link;
            end
            else
            begin
                newest_valid_next = 1'b0;
                oldest_valid_next = 1'b0;
            end
        end

        if (cmd.fix)
        begin
            // Link the freed slot onto the free stack
            ow_en   = 1'b1;
            ow_addr = s_reg;
            ow_data = link_reg;
        end
        else if (kind_reg != KIND_FREE)
        begin
            // Pop the free stack; a self link marks its bottom
            if (kind_reg == KIND_POP)
            begin
                freed_valid_next = (rd_older_reg != s_reg)
                                   && (32'(rd_older_reg) < SLOTS);
                freed_top_next   = rd_older_reg;
            end
            // Append the slot as newest
            if (newest_valid_next)
            begin
                ow_en   = cmd.exec;
                ow_addr = s_reg;
                ow_data = newest_next;
                nw_en   = cmd.exec;
                nw_addr = newest_next;
                nw_data = s_reg;
            end
            else
            begin
                oldest_valid_next = 1'b1;
                oldest_next       = s_reg;
            end
            newest_valid_next = 1'b1;
            newest_next       = s_reg;
        end
        else if (!bad_reg)
        begin
            if (both_sides)
            begin
                // Splice the neighbors together
                nw_en   = cmd.exec;
                nw_addr = o_link;
                nw_data = n_link;
                ow_en   = cmd.exec;
                ow_addr = n_link;
                ow_data = o_link;
            end
            else
            begin
                ow_en   = cmd.exec;
                ow_addr = s_reg;
                ow_data = free_link;
            end
            freed_valid_next = 1'b1;
            freed_top_next   = s_reg;
        end
    end

    assign sts.need_fix = both_sides && (kind_reg == KIND_FREE);

    // Write the link memories
    always_ff @(posedge clk)
    begin
        if (ow_en)
        begin
            older_mem[ow_addr] <= ow_data;
        end
        if (nw_en)
        begin
            newer_mem[nw_addr] <= nw_data;
        end
    end

    // Advance the pool state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg       <= '0;
            freed_valid_reg  <= 1'b0;
            freed_top_reg    <= '0;
            fill_count_reg   <= '0;
            newest_valid_reg <= 1'b0;
            newest_reg       <= '0;
            oldest_valid_reg <= 1'b0;
            oldest_reg       <= '0;
        end
        else
        begin
            if (cmd.load && (kind_load == KIND_FILL))
            begin
                fill_count_reg <= fill_count_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                freed_valid_reg  <= freed_valid_next;
                freed_top_reg    <= freed_top_next;
                newest_valid_reg <= newest_valid_next;
                newest_reg       <= newest_next;
                oldest_valid_reg <= oldest_valid_next;
                oldest_reg       <= oldest_next;
                if (kind_reg != KIND_FREE)
                begin
                    in_use_reg[s_reg] <= 1'b1;
                end
                else if (!bad_reg)
                begin
                    in_use_reg[s_reg] <= 1'b0;
                end
            end
        end
    end

    // Present the result word for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            granted_reg  <= (kind_reg == KIND_FREE) ? idx_reg : IDX_W'(s_reg);
            evicted_reg  <= (kind_reg == KIND_EVICT);
            bad_free_reg <= (kind_reg == KIND_FREE) && bad_reg;
        end
    end

    assign done         = done_reg;
    assign granted_slot = granted_reg;
    assign evicted      = evicted_reg;
    assign bad_free     = bad_free_reg;

endmodule

`default_nettype wire

[design/pool_allocator_evict_oldest.sv]
// Slot pool allocator with oldest-first eviction. Raise start with req_type
// and slot_index while busy is low; the request is taken at that edge. The
// result word appears on granted_slot, evicted and bad_free for exactly one
// cycle with done high, and must be captured then: there is no way to hold
// it off. The request is latched at the accepting edge; the last state of
// the request issues finish, and done is registered from it. A free of a
// slot with age-list neighbors on both sides passes the fix-up state: the
// older-link memory has a single write port, and that case writes it twice.
// A new request may be accepted in the cycle done is high. No clearing
// pass is needed after reset: in-use bits are flops that reset clears, and
// a link read from a never-written entry is never used.
`default_nettype none

`include "pool_allocator_evict_oldest_defines.svh"

module pool_allocator_evict_oldest (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          req_type,
    input  wire  [pae_pkg::IDX_W-1:0]    slot_index,
    output logic                         done,
    output logic [pae_pkg::IDX_W-1:0]    granted_slot,
    output logic                         evicted,
    output logic                         bad_free
);
    import pae_pkg::*;

    cmd_t    cmd;
    status_t sts;

    pae_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    pae_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req_type),
        .slot_index   (slot_index),
        .sts          (sts),
        .done         (done),
        .granted_slot (granted_slot),
        .evicted      (evicted),
        .bad_free     (bad_free)
    );

    // An accepted word keeps the block busy and clears the strobe
    `PAE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    // A result is shown only once the block is idle again
    `PAE_ASSERT(a_done_idle, clk, rst_n, !done || !busy)
    // Eviction and a rejected free never come together
    `PAE_ASSERT(a_flags_excl, clk, rst_n, !done || !(evicted && bad_free))
    // The fix-up step always ends the request
    `PAE_ASSERT_NEXT(a_fix_ends, clk, rst_n, cmd.fix, !busy && done)

endmodule

`default_nettype wire

[bench/pool_allocator_evict_oldest_check.sv]
`default_nettype none

module pool_allocator_evict_oldest_check (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire                          busy,
    input  wire                          req_type,
    input  wire  [pae_pkg::IDX_W-1:0]    slot_index,
    input  wire                          done,
    input  wire  [pae_pkg::IDX_W-1:0]    granted_slot,
    input  wire                          evicted,
    input  wire                          bad_free,
    output int                           errors,
    output int                           pending
);

    import pae_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // One result word as the block should give it
    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic             evicted;
        logic             bad_free;
    } grant_word_t;

    // Mirror of the pool: age list, free stack and fill pointer
    logic [SLOT_W-1:0] newer_link [SLOTS];
    logic [SLOT_W-1:0] older_link [SLOTS];
    bit                in_use     [SLOTS];
    logic [SLOT_W:0]   freed_top;
    logic [SLOT_W:0]   fill_count;
    logic [SLOT_W:0]   newest_slot;
    logic [SLOT_W:0]   oldest_slot;

    grant_word_t grant_q [$];
    int          mismatches;

    // Take a slot out of the age list; ends are found by comparing with the
    // newest and oldest pointers, never by following their links
    task automatic unlink_age(input int s);
        int  o;
        int  n;
        bit  has_older;
        bit  has_newer;
        o = int'(older_link[s]);
        n = int'(newer_link[s]);
        has_older = (s != oldest_slot);
        has_newer = (s != newest_slot);
        if (has_older && has_newer)
        begin
            newer_link[o] = n[SLOT_W-1:0];
            older_link[n] = o[SLOT_W-1:0];
        end
        else if (has_older)
        begin
            newest_slot = o[SLOT_W:0];
        end
        else if (has_newer)
        begin
            oldest_slot = n[SLOT_W:0];
        end
        else
        begin
            newest_slot = SLOTS[SLOT_W:0];
            oldest_slot = SLOTS[SLOT_W:0];
        end
    endtask

    // Advance the mirror by one request and queue the word it should produce
    task automatic predict_grant(input logic rt, input logic [IDX_W-1:0] idx);
        grant_word_t w;
        int          s;
        int          nxt;
        w = '0;
        if (rt == REQ_ALLOC)
        begin
            if (freed_top < SLOTS)
            begin
                // pop the free stack; a self link marks its bottom
                s = int'(freed_top);
                nxt = int'(older_link[s]);
                freed_top = (nxt == s) ? SLOTS[SLOT_W:0] : nxt[SLOT_W:0];
            end
            else if (fill_count < SLOTS)
            begin
                s = int'(fill_count);
                fill_count = fill_count + 1'b1;
            end
            else
            begin
                // pool full: reuse the oldest slot in use
                s = (oldest_slot < SLOTS) ? int'(oldest_slot) : 0;
                if (oldest_slot < SLOTS && in_use[s])
                    unlink_age(s);
                w.evicted = 1'b1;
            end
            // make it the newest entry
            if (newest_slot < SLOTS)
            begin
                older_link[s] = newest_slot[SLOT_W-1:0];
                newer_link[newest_slot[SLOT_W-1:0]] = s[SLOT_W-1:0];
            end
            else
            begin
                oldest_slot = s[SLOT_W:0];
            end
            newest_slot = s[SLOT_W:0];
            in_use[s] = 1'b1;
            w.slot = s[IDX_W-1:0];
        end
        else
        begin
            s = int'(idx);
            if (s >= SLOTS || !in_use[s])
            begin
                w.bad_free = 1'b1;
            end
            else
            begin
                unlink_age(s);
                in_use[s] = 1'b0;
                older_link[s] = (freed_top < SLOTS) ? freed_top[SLOT_W-1:0] : s[SLOT_W-1:0];
                freed_top = s[SLOT_W:0];
            end
            w.slot = idx;
        end
        grant_q.push_back(w);
    endtask

    // Compare each result word with the oldest prediction, then take new requests
    always @(posedge clk or negedge rst_n)
    begin
        grant_word_t want;
        if (!rst_n)
        begin
            foreach (in_use[i])
            begin
                in_use[i] = 1'b0;
                newer_link[i] = '0;
                older_link[i] = '0;
            end
            freed_top   = SLOTS[SLOT_W:0];
            fill_count  = '0;
            newest_slot = SLOTS[SLOT_W:0];
            oldest_slot = SLOTS[SLOT_W:0];
            grant_q.delete();
            mismatches  = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (grant_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result word with nothing pending: slot %0d ev %0b bad %0b",
                                 $realtime, granted_slot, evicted, bad_free);
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (granted_slot !== want.slot || evicted !== want.evicted
                        || bad_free !== want.bad_free)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $write("%0t: mismatch: expected slot %0d ev %0b bad %0b,",
                                   $realtime, want.slot, want.evicted, want.bad_free);
                            $display(" got slot %0d ev %0b bad %0b",
                                     granted_slot, evicted, bad_free);
                        end
                    end
                end
            end
            if (start && !busy)
                predict_grant(req_type, slot_index);
            errors  <= mismatches;
            pending <= grant_q.size();
        end
    end

endmodule

`default_nettype wire

[bench/pool_allocator_evict_oldest_test.sv]
`default_nettype none

module pool_allocator_evict_oldest_test;

    import pae_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SEGMENTS    = 9;
    localparam int SEG_WORDS   = 100;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             start      = 1'b0;
    logic             req_type   = REQ_ALLOC;
    logic [IDX_W-1:0] slot_index = '0;
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] granted_slot;
    logic             evicted;
    logic             bad_free;
    int               errors;
    int               pending;
    int               alloc_issued = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pool_allocator_evict_oldest dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .slot_index   (slot_index),
        .done         (done),
        .granted_slot (granted_slot),
        .evicted      (evicted),
        .bad_free     (bad_free)
    );

    pool_allocator_evict_oldest_check checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .slot_index   (slot_index),
        .done         (done),
        .granted_slot (granted_slot),
        .evicted      (evicted),
        .bad_free     (bad_free),
        .errors       (errors),
        .pending      (pending)
    );

    // Mostly back to back, sometimes a short pause, rarely a long one
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold start high with the word until the block takes it
    task automatic send_word(input logic rt, input logic [IDX_W-1:0] idx, input bit steady);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= rt;
        slot_index <= idx;
        if (rt == REQ_ALLOC)
            alloc_issued++;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop the run if nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int   pct;
        int   hi;
        bit   steady;
        logic rt;
        logic [IDX_W-1:0] idx;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Frees on an empty pool, lowest and highest index
        send_word(REQ_FREE, 8'd0, 1'b0);
        send_word(REQ_FREE, 8'hFF, 1'b0);
        // Fill four slots in index order; the index field is ignored here
        send_word(REQ_ALLOC, 8'hFF, 1'b0);
        send_word(REQ_ALLOC, 8'h00, 1'b0);
        send_word(REQ_ALLOC, 8'hAA, 1'b0);
        send_word(REQ_ALLOC, 8'h55, 1'b0);
        // Unlink from the middle, the newest end, the oldest end, then the last one
        send_word(REQ_FREE, 8'd1, 1'b0);
        send_word(REQ_FREE, 8'd3, 1'b0);
        send_word(REQ_FREE, 8'd0, 1'b0);
        send_word(REQ_FREE, 8'd2, 1'b0);
        // Double free
        send_word(REQ_FREE, 8'd2, 1'b0);
        // Drain the free stack down to its self-linked bottom, then fill again
        repeat (5) send_word(REQ_ALLOC, IDX_W'($urandom_range(0, 255)), 1'b0);
        send_word(REQ_FREE, 8'hFF, 1'b1);

        // Random segments: the first ones fill the pool so eviction follows
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            pct = (seg < 3) ? 95 : $urandom_range(30, 95);
            steady = (seg % 3 == 2);
            repeat (SEG_WORDS) begin
                rt = ($urandom_range(0, 99) < pct) ? REQ_ALLOC : REQ_FREE;
                hi = (alloc_issued < SLOTS) ? alloc_issued - 1 : SLOTS - 1;
                if (rt == REQ_ALLOC || hi < 0 || $urandom_range(0, 9) == 0)
                    idx = IDX_W'($urandom_range(0, 255));
                else
                    idx = IDX_W'($urandom_range(0, hi));
                send_word(rt, idx, steady);
            end
        end
        start <= 1'b0;

        // Drain outstanding words, then allow for the slowest path
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
